// File: rtl/chwr_pkg.sv
package chwr_pkg;

  // Length of the arctangent table; more steps than this add nothing.
  localparam int ATAN_LEN = 24;

  typedef logic [4:0] step_idx_t;

  // Commands from the controller to the datapath, one strobe per phase.
  typedef struct packed {
    logic      load;
    logic      iter;
    logic      mul;
    logic      rnd;
    logic      finish;
    step_idx_t step;
  } cmd_t;

  // atan(2^-i) as a binary angle, one full turn is 2^32.
  function automatic logic [31:0] atan_turn(input step_idx_t idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/chwr_ctrl.sv
module chwr_ctrl #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output chwr_pkg::cmd_t cmd
);
  import chwr_pkg::*;

  localparam int NSTEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int STEP_W = $clog2(NSTEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ITER = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_RND  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.step      = step_idx_t'(step_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = S_ITER;
        end
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(NSTEPS - 1)) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_RND;
      end
      S_RND: begin
        cmd.rnd   = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold the result until the output register is free
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result written over an item not yet taken");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_ITER && step_r == '0))
    else $error("accepted item did not start the rotations");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> $past(!out_stall))
    else $error("result dropped while stalled");

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ITER) |-> (step_r <= STEP_W'(NSTEPS - 1)))
    else $error("rotation count out of range");

endmodule

// File: rtl/chwr_dp.sv
module chwr_dp #(
  parameter int ANGLE_FRAC_BITS = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  chwr_pkg::cmd_t      cmd,
  input  logic                operation,
  input  logic signed [15:0]  field_x,
  input  logic signed [15:0]  field_y,
  output logic [14:0]         raw_heading,
  output logic [14:0]         relative_heading
);
  import chwr_pkg::*;

  localparam int HW = 9 + ANGLE_FRAC_BITS;
  localparam int PW = 32 + HW;
  localparam logic [HW-1:0] FULL_TURN = HW'(360 << ANGLE_FRAC_BITS);

  logic signed [32:0] re_r, im_r, re_nxt, im_nxt;
  logic signed [32:0] sx_ext, sy_ext, dre, dim;
  logic [31:0]        z_r, z_nxt, atan_v;
  logic               zero_r, op_r;
  logic [PW-1:0]      prod_r;
  logic [PW:0]        rsum;
  logic [HW-1:0]      h, raw_nxt, raw_r, ref_r, ref_eff;
  logic [HW:0]        diff;
  logic [HW-1:0]      rel;
  logic [14:0]        out_raw_r, out_rel_r;

  assign sx_ext = 33'(field_x) <<< 14;
  assign sy_ext = 33'(field_y) <<< 14;
  assign dre    = im_r >>> cmd.step;
  assign dim    = re_r >>> cmd.step;
  assign atan_v = atan_turn(cmd.step);

  always_comb begin
    if (cmd.load) begin
      // fold the left half plane over by half a turn
      if (field_y < 0) begin
        re_nxt = -sy_ext;
        im_nxt = -sx_ext;
        z_nxt  = 32'h80000000;
      end else begin
        re_nxt = sy_ext;
        im_nxt = sx_ext;
        z_nxt  = 32'h0;
      end
    end else if (im_r > 0) begin
      re_nxt = re_r + dre;
      im_nxt = im_r - dim;
      z_nxt  = z_r + atan_v;
    end else begin
      re_nxt = re_r - dre;
      im_nxt = im_r + dim;
      z_nxt  = z_r - atan_v;
    end
  end

  // round the binary angle to heading units; a full turn wraps to zero
  assign rsum    = {1'b0, prod_r} + (PW+1)'(33'h080000000);
  assign h       = rsum[PW-1:32];
  assign raw_nxt = (zero_r || h >= FULL_TURN) ? '0 : h;

  assign ref_eff = op_r ? raw_r : ref_r;
  assign diff    = {1'b0, ref_eff} - {1'b0, raw_r};
  assign rel     = diff[HW] ? (diff[HW-1:0] + FULL_TURN) : diff[HW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.iter) begin
      re_r <= re_nxt;
      im_r <= im_nxt;
      z_r  <= z_nxt;
    end
    if (cmd.load) begin
      zero_r <= (field_x == 16'sd0) && (field_y == 16'sd0);
      op_r   <= operation;
    end
    if (cmd.mul) begin
      prod_r <= PW'(z_r) * PW'(FULL_TURN);
    end
    if (cmd.rnd) begin
      raw_r <= raw_nxt;
    end
    if (cmd.finish) begin
      out_raw_r <= 15'(raw_r);
      out_rel_r <= 15'(rel);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r <= '0;
    end else if (cmd.finish) begin
      ref_r <= ref_eff;
    end
  end

  assign raw_heading      = out_raw_r;
  assign relative_heading = out_rel_r;

endmodule

// File: rtl/compass_heading_with_reference_top.sv
// Compass heading from one two-axis magnetometer sample per item. The raw
// heading is atan2(field_x, field_y) wrapped to [0, 360) degrees in unsigned
// fixed point with ANGLE_FRAC_BITS fraction bits (1/64 degree by default,
// within one LSB of exact); a zero vector reads as 0. The relative heading
// is reference minus raw, wrapped to [0, 360). With operation set, the
// reference first takes this sample's raw heading, so its relative heading
// is 0; reset puts the reference at 0 (magnetic north). Both outputs carry
// the low 15 bits of the heading. One item is worked at a time; from
// acceptance until the block can take the next one, an item passes
// through the load of the sample, min(CORDIC_STEPS, 24) steps of the
// single CORDIC rotation unit, then the turn-to-degree multiply, the
// rounding and the reference update. The result sits in an output
// register, so a new item is accepted while the previous result still
// waits; a stalled output only holds the final step.
module compass_heading_with_reference_top #(
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic signed [15:0] in_field_x,
  input  logic signed [15:0] in_field_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [14:0]        out_raw_heading,
  output logic [14:0]        out_relative_heading
);
  import chwr_pkg::*;

  cmd_t cmd;

  // sequence the load, rotations, scaling and writeback
  chwr_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  // rotate, scale to heading units and hold the reference
  chwr_dp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .operation       (in_operation),
    .field_x         (in_field_x),
    .field_y         (in_field_y),
    .raw_heading     (out_raw_heading),
    .relative_heading(out_relative_heading)
  );

endmodule
